// File: rtl/core/ledpg_pkg.sv
// ----------------------------------------------------------------------------
// ledpg_pkg
// Shared types and constants of the four-channel LED pattern generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ledpg_pkg;

    localparam int NUM_CH = 4;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [2:0] MODE_OFF           = 3'd0;
    localparam logic [2:0] MODE_ON            = 3'd1;
    localparam logic [2:0] MODE_BLINK_ONCE    = 3'd2;
    localparam logic [2:0] MODE_BLINK_FOREVER = 3'd3;
    localparam logic [2:0] MODE_BREATHE       = 3'd4;

    localparam logic [1:0] CH_PGOOD   = 2'd0;
    localparam logic [1:0] CH_CHARGER = 2'd1;
    localparam logic [1:0] CH_UART    = 2'd2;
    localparam logic [1:0] CH_DAP     = 2'd3;

    localparam logic [1:0] REG_MAX_LEVEL    = 2'd0;
    localparam logic [1:0] REG_BREATHE_STEP = 2'd1;

    localparam logic [7:0] MAX_LEVEL_RESET    = 8'd80;
    localparam logic [7:0] BREATHE_STEP_RESET = 8'd2;

    typedef struct packed {
        logic       command;
        logic [1:0] channel;
        logic [2:0] mode;
    } cmd_t;

    typedef struct packed {
        logic [7:0] level_pgood;
        logic [7:0] level_charger;
        logic [7:0] level_uart;
        logic [7:0] level_dap;
        logic [3:0] updated_mask;
    } result_t;

    typedef struct packed {
        logic [7:0] max_level;
        logic [7:0] breathe_step;
    } cfg_t;

    typedef struct packed {
        logic [7:0] level;
        logic       active;
        logic [2:0] mode;
        logic       rising;
    } chan_upd_t;

endpackage

`default_nettype wire

// File: rtl/core/ledpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// ledpg_cfg_regs
// Configuration registers: maximum level and breathe step.
// ----------------------------------------------------------------------------
`default_nettype none

module ledpg_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data,
    output ledpg_pkg::cfg_t     cfg
);

    import ledpg_pkg::*;

    logic [7:0] max_level_reg;
    logic [7:0] breathe_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg    <= MAX_LEVEL_RESET;
            breathe_step_reg <= BREATHE_STEP_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_MAX_LEVEL)
            begin
                max_level_reg <= cfg_data;
            end
            if (cfg_index == REG_BREATHE_STEP)
            begin
                breathe_step_reg <= cfg_data;
            end
        end
    end

    assign cfg.max_level    = max_level_reg;
    assign cfg.breathe_step = breathe_step_reg;

endmodule

`default_nettype wire

// File: rtl/core/ledpg_channel.sv
// ----------------------------------------------------------------------------
// ledpg_channel
// One tick step of a single LED channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ledpg_channel (
    input  wire logic [1:0]     ch_id,
    input  wire logic [2:0]     mode,
    input  wire logic [7:0]     level,
    input  wire logic           rising,
    input  wire ledpg_pkg::cfg_t cfg,
    output ledpg_pkg::chan_upd_t upd
);

    import ledpg_pkg::*;

    logic [8:0] sum;
    logic [7:0] blink_level;

    assign sum         = {1'b0, level} + {1'b0, cfg.breathe_step};
    assign blink_level = (level != 8'd0) ? 8'd0 : cfg.max_level;

    always_comb
    begin
        upd.level  = level;
        upd.active = 1'b1;
        upd.mode   = mode;
        upd.rising = rising;
        if (mode == MODE_ON && ch_id != CH_DAP)
        begin
            upd.level = cfg.max_level;
        end
        else if (mode == MODE_BLINK_ONCE || mode == MODE_BLINK_FOREVER)
        begin
            upd.level = blink_level;
            if (blink_level == 8'd0 && mode == MODE_BLINK_ONCE)
            begin
                upd.active = 1'b0;
                upd.mode   = MODE_OFF;
            end
        end
        else if (mode == MODE_BREATHE && ch_id == CH_CHARGER)
        begin
            if (rising)
            begin
                if (sum > {1'b0, cfg.max_level})
                begin
                    upd.rising = 1'b0;
                end
                else
                begin
                    upd.level = sum[7:0];
                end
            end
            else if (level > cfg.breathe_step)
            begin
                upd.level = level - cfg.breathe_step;
            end
            else
            begin
                upd.level  = 8'd0;
                upd.rising = 1'b1;
            end
        end
        else
        begin
            upd.level  = 8'd0;
            upd.active = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/four_channel_led_pattern_generator_core.sv
// ----------------------------------------------------------------------------
// four_channel_led_pattern_generator_core
// Four-channel LED pattern generator with set and tick commands.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction
//  command   cmd_valid, cmd_ready, cmd        in
//  result    res_valid, res_ready, res        out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
//  Items pass an input register, the update logic and a result register; one is
//  taken every cycle unless a stalled result register holds the input register.
//  The channel state is updated in the cycle the item moves to the result register.
//  Reset clears valid flags, levels, modes and active bits; config takes defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_led_pattern_generator_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output      logic           cmd_ready,
    input  wire ledpg_pkg::cmd_t cmd,
    output      logic           res_valid,
    input  wire logic           res_ready,
    output ledpg_pkg::result_t  res,
    input  wire logic           cfg_valid,
    output      logic           cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data
);

    import ledpg_pkg::*;

    cfg_t       cfg;
    logic       s1_valid_reg;
    cmd_t       s1_item_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       advance;

    logic [NUM_CH-1:0]       active_reg;
    logic [NUM_CH-1:0]       active_next;
    logic [NUM_CH-1:0][2:0]  mode_reg;
    logic [NUM_CH-1:0][2:0]  mode_next;
    logic [NUM_CH-1:0][7:0]  level_reg;
    logic [NUM_CH-1:0][7:0]  level_next;
    logic                    rising_reg;
    logic                    rising_next;
    logic [NUM_CH-1:0]       mask;
    chan_upd_t [NUM_CH-1:0]  upd;

    ledpg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_ch
        ledpg_channel u_ch (
            .ch_id  (2'(i)),
            .mode   (mode_reg[i]),
            .level  (level_reg[i]),
            .rising (rising_reg),
            .cfg    (cfg),
            .upd    (upd[i])
        );
    end

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !s1_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        level_next  = level_reg;
        rising_next = rising_reg;
        mask        = '0;
        if (s1_item_reg.command == CMD_SET)
        begin
            active_next[s1_item_reg.channel] = 1'b1;
            mode_next[s1_item_reg.channel]   = s1_item_reg.mode;
        end
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (active_reg[c])
                begin
                    mask[c]        = 1'b1;
                    level_next[c]  = upd[c].level;
                    active_next[c] = upd[c].active;
                    mode_next[c]   = upd[c].mode;
                    if (2'(c) == CH_CHARGER)
                    begin
                        rising_next = upd[c].rising;
                    end
                end
            end
        end
        res_next.level_pgood   = level_next[CH_PGOOD];
        res_next.level_charger = level_next[CH_CHARGER];
        res_next.level_uart    = level_next[CH_UART];
        res_next.level_dap     = level_next[CH_DAP];
        res_next.updated_mask  = mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            active_reg    <= '0;
            mode_reg      <= {NUM_CH{MODE_OFF}};
            level_reg     <= '0;
            rising_reg    <= 1'b1;
        end
        else
        begin
            if (cmd_ready)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                active_reg    <= active_next;
                mode_reg      <= mode_next;
                level_reg     <= level_next;
                rising_reg    <= rising_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_item_reg <= cmd;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
